// ===== hw/rtl/rv32i_decode_execute_assert.svh =====
// assertion macros for the rv32i decode/execute block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RV32I_DECODE_EXECUTE_ASSERT_SVH
`define RV32I_DECODE_EXECUTE_ASSERT_SVH

// checked on every clock edge outside reset
`define RVDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define RVDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/rvde_pkg.sv =====
// shared types and constants for the rv32i decode/execute block
// opcodes, funct codes, memory and status codes, decode and result structs
package rvde_pkg;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;

  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;

  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // addi x10, rs1, 255 marks the end of a program
  localparam logic [4:0]  HALT_RD  = 5'd10;
  localparam logic [31:0] HALT_IMM = 32'h0000_00ff;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [3:0] {
    MEM_NONE = 4'd0,
    MEM_LB   = 4'd1,
    MEM_LH   = 4'd2,
    MEM_LW   = 4'd3,
    MEM_LBU  = 4'd4,
    MEM_LHU  = 4'd5,
    MEM_SB   = 4'd6,
    MEM_SH   = 4'd7,
    MEM_SW   = 4'd8
  } mem_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_HALT    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_SLL  = 4'd2,
    ALU_SLT  = 4'd3,
    ALU_SLTU = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_SRL  = 4'd6,
    ALU_SRA  = 4'd7,
    ALU_OR   = 4'd8,
    ALU_AND  = 4'd9
  } alu_op_e;

  typedef enum logic [1:0] {
    OPA_RS1  = 2'd0,
    OPA_PC   = 2'd1,
    OPA_ZERO = 2'd2
  } opa_sel_e;

  typedef struct packed {
    logic        legal;
    logic        halt;
    logic        has_rd;
    logic [4:0]  rd;
    alu_op_e     alu_op;
    opa_sel_e    a_sel;
    logic        use_imm;
    logic [31:0] imm;
    mem_kind_e   kind;
    logic        is_branch;
    logic        is_jal;
    logic        is_jalr;
    logic [2:0]  f3;
  } dec_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] store_data;
    logic [31:0] mem_address;
    mem_kind_e   mem_kind;
    logic [31:0] next_pc;
    logic [31:0] wb_value;
    logic [4:0]  wb_reg;
    logic        wb_enable;
  } res_t;

endpackage

// ===== hw/rtl/rvde_decode.sv =====
// instruction decoder: rv32i matching for the opcodes in rvde_pkg, immediate build, control struct
// depends on rvde_pkg
module rvde_decode (
  input  logic [31:0]   instr_i,
  output rvde_pkg::dec_t dec_o
);

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  assign opcode = instr_i[6:0];
  assign f3     = instr_i[14:12];
  assign f7     = instr_i[31:25];

  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign imm_j = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};

  always_comb begin
    dec_o           = '0;
    dec_o.rd        = instr_i[11:7];
    dec_o.f3        = f3;
    dec_o.alu_op    = rvde_pkg::ALU_ADD;
    dec_o.a_sel     = rvde_pkg::OPA_RS1;
    dec_o.kind      = rvde_pkg::MEM_NONE;
    dec_o.imm       = imm_i;
    unique case (opcode)
      rvde_pkg::OPC_LUI: begin
        dec_o.legal   = 1'b1;
        dec_o.has_rd  = 1'b1;
        dec_o.a_sel   = rvde_pkg::OPA_ZERO;
        dec_o.use_imm = 1'b1;
        dec_o.imm     = imm_u;
      end
      rvde_pkg::OPC_AUIPC: begin
        dec_o.legal   = 1'b1;
        dec_o.has_rd  = 1'b1;
        dec_o.a_sel   = rvde_pkg::OPA_PC;
        dec_o.use_imm = 1'b1;
        dec_o.imm     = imm_u;
      end
      rvde_pkg::OPC_JAL: begin
        dec_o.legal  = 1'b1;
        dec_o.has_rd = 1'b1;
        dec_o.is_jal = 1'b1;
        dec_o.imm    = imm_j;
      end
      rvde_pkg::OPC_JALR: begin
        dec_o.legal   = (f3 == rvde_pkg::F3_JALR);
        dec_o.has_rd  = 1'b1;
        dec_o.is_jalr = 1'b1;
        dec_o.use_imm = 1'b1;
      end
      rvde_pkg::OPC_BRANCH: begin
        dec_o.legal     = (f3 == rvde_pkg::F3_BEQ) || (f3 == rvde_pkg::F3_BNE) ||
                          (f3 == rvde_pkg::F3_BLT) || (f3 == rvde_pkg::F3_BGE) ||
                          (f3 == rvde_pkg::F3_BLTU) || (f3 == rvde_pkg::F3_BGEU);
        dec_o.is_branch = 1'b1;
        dec_o.imm       = imm_b;
      end
      rvde_pkg::OPC_LOAD: begin
        dec_o.has_rd  = 1'b1;
        dec_o.use_imm = 1'b1;
        dec_o.legal   = 1'b1;
        unique case (f3)
          rvde_pkg::F3_LB:  dec_o.kind = rvde_pkg::MEM_LB;
          rvde_pkg::F3_LH:  dec_o.kind = rvde_pkg::MEM_LH;
          rvde_pkg::F3_LW:  dec_o.kind = rvde_pkg::MEM_LW;
          rvde_pkg::F3_LBU: dec_o.kind = rvde_pkg::MEM_LBU;
          rvde_pkg::F3_LHU: dec_o.kind = rvde_pkg::MEM_LHU;
          default:          dec_o.legal = 1'b0;
        endcase
      end
      rvde_pkg::OPC_STORE: begin
        dec_o.use_imm = 1'b1;
        dec_o.imm     = imm_s;
        dec_o.legal   = 1'b1;
        unique case (f3)
          rvde_pkg::F3_SB: dec_o.kind = rvde_pkg::MEM_SB;
          rvde_pkg::F3_SH: dec_o.kind = rvde_pkg::MEM_SH;
          rvde_pkg::F3_SW: dec_o.kind = rvde_pkg::MEM_SW;
          default:         dec_o.legal = 1'b0;
        endcase
      end
      rvde_pkg::OPC_OP_IMM: begin
        dec_o.legal   = 1'b1;
        dec_o.has_rd  = 1'b1;
        dec_o.use_imm = 1'b1;
        unique case (f3)
          rvde_pkg::F3_ADD: begin
            dec_o.alu_op = rvde_pkg::ALU_ADD;
            dec_o.halt   = (instr_i[11:7] == rvde_pkg::HALT_RD) &&
                           (imm_i == rvde_pkg::HALT_IMM);
          end
          rvde_pkg::F3_SLT:  dec_o.alu_op = rvde_pkg::ALU_SLT;
          rvde_pkg::F3_SLTU: dec_o.alu_op = rvde_pkg::ALU_SLTU;
          rvde_pkg::F3_XOR:  dec_o.alu_op = rvde_pkg::ALU_XOR;
          rvde_pkg::F3_OR:   dec_o.alu_op = rvde_pkg::ALU_OR;
          rvde_pkg::F3_AND:  dec_o.alu_op = rvde_pkg::ALU_AND;
          rvde_pkg::F3_SLL: begin
            dec_o.alu_op = rvde_pkg::ALU_SLL;
            dec_o.legal  = (f7 == rvde_pkg::F7_ZERO);
          end
          default: begin
            // shift right, logical or arithmetic by funct7
            dec_o.alu_op = (f7 == rvde_pkg::F7_ALT) ? rvde_pkg::ALU_SRA : rvde_pkg::ALU_SRL;
            dec_o.legal  = (f7 == rvde_pkg::F7_ZERO) || (f7 == rvde_pkg::F7_ALT);
          end
        endcase
      end
      rvde_pkg::OPC_OP: begin
        dec_o.has_rd = 1'b1;
        dec_o.legal  = 1'b1;
        unique case (f3)
          rvde_pkg::F3_ADD:  dec_o.alu_op = rvde_pkg::ALU_ADD;
          rvde_pkg::F3_SLL:  dec_o.alu_op = rvde_pkg::ALU_SLL;
          rvde_pkg::F3_SLT:  dec_o.alu_op = rvde_pkg::ALU_SLT;
          rvde_pkg::F3_SLTU: dec_o.alu_op = rvde_pkg::ALU_SLTU;
          rvde_pkg::F3_XOR:  dec_o.alu_op = rvde_pkg::ALU_XOR;
          rvde_pkg::F3_SR:   dec_o.alu_op = rvde_pkg::ALU_SRL;
          rvde_pkg::F3_OR:   dec_o.alu_op = rvde_pkg::ALU_OR;
          default:           dec_o.alu_op = rvde_pkg::ALU_AND;
        endcase
        if (f7 == rvde_pkg::F7_ALT) begin
          // only sub and sra use the alternate funct7
          if (f3 == rvde_pkg::F3_ADD) begin
            dec_o.alu_op = rvde_pkg::ALU_SUB;
          end else if (f3 == rvde_pkg::F3_SR) begin
            dec_o.alu_op = rvde_pkg::ALU_SRA;
          end else begin
            dec_o.legal = 1'b0;
          end
        end else if (f7 != rvde_pkg::F7_ZERO) begin
          dec_o.legal = 1'b0;
        end
      end
      default: dec_o.legal = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/rvde_execute.sv =====
// execute logic: alu, branch compare, next pc, memory request, result fields
// depends on rvde_pkg
module rvde_execute (
  input  rvde_pkg::dec_t dec_i,
  input  logic [31:0]    pc_i,
  input  logic [31:0]    rs1_i,
  input  logic [31:0]    rs2_i,
  output rvde_pkg::res_t res_o
);

  logic [31:0] op_a, op_b, alu_res, seq_pc, target_pc, npc;
  logic [4:0]  shamt;
  logic        take, is_load, is_store;

  always_comb begin
    unique case (dec_i.a_sel)
      rvde_pkg::OPA_RS1: op_a = rs1_i;
      rvde_pkg::OPA_PC:  op_a = pc_i;
      default:           op_a = '0;
    endcase
  end

  assign op_b  = dec_i.use_imm ? dec_i.imm : rs2_i;
  assign shamt = op_b[4:0];

  always_comb begin
    unique case (dec_i.alu_op)
      rvde_pkg::ALU_ADD:  alu_res = op_a + op_b;
      rvde_pkg::ALU_SUB:  alu_res = op_a - op_b;
      rvde_pkg::ALU_SLL:  alu_res = op_a << shamt;
      rvde_pkg::ALU_SLT:  alu_res = {31'b0, $signed(op_a) < $signed(op_b)};
      rvde_pkg::ALU_SLTU: alu_res = {31'b0, op_a < op_b};
      rvde_pkg::ALU_XOR:  alu_res = op_a ^ op_b;
      rvde_pkg::ALU_SRL:  alu_res = op_a >> shamt;
      rvde_pkg::ALU_SRA:  alu_res = $unsigned($signed(op_a) >>> shamt);
      rvde_pkg::ALU_OR:   alu_res = op_a | op_b;
      rvde_pkg::ALU_AND:  alu_res = op_a & op_b;
      default:            alu_res = '0;
    endcase
  end

  always_comb begin
    unique case (dec_i.f3)
      rvde_pkg::F3_BEQ:  take = (rs1_i == rs2_i);
      rvde_pkg::F3_BNE:  take = (rs1_i != rs2_i);
      rvde_pkg::F3_BLT:  take = $signed(rs1_i) < $signed(rs2_i);
      rvde_pkg::F3_BGE:  take = $signed(rs1_i) >= $signed(rs2_i);
      rvde_pkg::F3_BLTU: take = rs1_i < rs2_i;
      rvde_pkg::F3_BGEU: take = rs1_i >= rs2_i;
      default:           take = 1'b0;
    endcase
  end

  assign seq_pc    = pc_i + rvde_pkg::PC_STEP;
  assign target_pc = pc_i + dec_i.imm;

  always_comb begin
    priority if (dec_i.is_jalr) begin
      // alu holds rs1 + imm, bit 0 cleared
      npc = {alu_res[31:1], 1'b0};
    end else if (dec_i.is_jal || (dec_i.is_branch && take)) begin
      npc = target_pc;
    end else begin
      npc = seq_pc;
    end
  end

  assign is_load  = (dec_i.kind == rvde_pkg::MEM_LB) || (dec_i.kind == rvde_pkg::MEM_LH) ||
                    (dec_i.kind == rvde_pkg::MEM_LW) || (dec_i.kind == rvde_pkg::MEM_LBU) ||
                    (dec_i.kind == rvde_pkg::MEM_LHU);
  assign is_store = (dec_i.kind == rvde_pkg::MEM_SB) || (dec_i.kind == rvde_pkg::MEM_SH) ||
                    (dec_i.kind == rvde_pkg::MEM_SW);

  always_comb begin
    res_o         = '0;
    res_o.next_pc = seq_pc;
    res_o.mem_kind = rvde_pkg::MEM_NONE;
    res_o.status  = rvde_pkg::ST_OK;
    if (!dec_i.legal) begin
      res_o.status = rvde_pkg::ST_ILLEGAL;
    end else if (dec_i.halt) begin
      res_o.status = rvde_pkg::ST_HALT;
    end else begin
      res_o.wb_enable   = dec_i.has_rd && (dec_i.rd != 5'd0);
      res_o.wb_reg      = dec_i.has_rd ? dec_i.rd : 5'd0;
      res_o.next_pc     = npc;
      res_o.mem_kind    = dec_i.kind;
      res_o.mem_address = (is_load || is_store) ? alu_res : 32'd0;
      res_o.store_data  = is_store ? rs2_i : 32'd0;
      priority if (dec_i.is_jal || dec_i.is_jalr) begin
        res_o.wb_value = seq_pc;
      end else if (is_load || is_store || dec_i.is_branch) begin
        res_o.wb_value = '0;
      end else begin
        res_o.wb_value = alu_res;
      end
    end
  end

endmodule

// ===== hw/rtl/rv32i_decode_execute.sv =====
// rv32i decode/execute top: input register, decode, execute, result register
// depends on rvde_pkg, rvde_decode, rvde_execute, rv32i_decode_execute_assert.svh
//
// channel  dir  fields (tdata, lowest bit first)
// s_axis   in   instruction[31:0] pc[63:32] rs1_value[95:64] rs2_value[127:96]
// m_axis   out  wb_enable[0] wb_reg[5:1] wb_value[37:6] next_pc[69:38]
//               mem_kind[73:70] mem_address[105:74] store_data[137:106]
//               status[139:138], zeros[143:140]
//
// one item per cycle sustained while m_axis does not stall; an accepted item is held in
// the stage one register and then in the result register, which drives m_axis
// stage one registers the input item, decode and execute run between that register
// and the result register; stages advance whenever the next one is empty or drains
// reset clears both stage valid flags; payload registers are not reset
// a stall on m_axis holds the result register and, once stage one is full, s_axis
`include "rv32i_decode_execute_assert.svh"
module rv32i_decode_execute (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // instruction, pc, rs1_value, rs2_value
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // wb_enable, wb_reg, wb_value, next_pc, mem_kind, mem_address, store_data, status
  output logic [143:0] m_axis_tdata_o
);

  logic           in_valid_q;
  logic [127:0]   in_data_q;
  logic           out_valid_q;
  rvde_pkg::res_t res_q, res_d;
  rvde_pkg::dec_t dec;
  logic           out_ready, in_ready;
  logic           res_fault, res_side_effect, res_store;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign in_ready        = !in_valid_q || out_ready;
  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  rvde_decode u_decode (
    .instr_i (in_data_q[31:0]),
    .dec_o   (dec)
  );

  rvde_execute u_execute (
    .dec_i (dec),
    .pc_i  (in_data_q[63:32]),
    .rs1_i (in_data_q[95:64]),
    .rs2_i (in_data_q[127:96]),
    .res_o (res_d)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, res_q};

  assign res_fault       = (res_q.status != rvde_pkg::ST_OK);
  assign res_side_effect = res_q.wb_enable || (res_q.mem_kind != rvde_pkg::MEM_NONE);
  assign res_store       = (res_q.mem_kind == rvde_pkg::MEM_SB) ||
                           (res_q.mem_kind == rvde_pkg::MEM_SH) ||
                           (res_q.mem_kind == rvde_pkg::MEM_SW);

  `RVDE_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")
  `RVDE_ASSERT(a_stage_advance, in_valid_q && out_ready |=> out_valid_q, "stage one item lost")
  `RVDE_ASSERT(a_x0_no_write, out_valid_q && res_q.wb_enable |-> res_q.wb_reg != 5'd0, "x0 write")
  `RVDE_ASSERT(a_fault_quiet, out_valid_q && res_fault |-> !res_side_effect, "fault side effect")
  `RVDE_ASSERT(a_store_no_wb, out_valid_q && res_store |-> !res_q.wb_enable, "store writes back")

endmodule
